>>> src/peu_pkg.sv
package peu_pkg;

    localparam int FRAC_BITS = 16;

    localparam longint unsigned GRAV_RAW =
        ((64'd4903325 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned PAD_RAW = ((64'd5 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [15:0] GRAVITY_RESET = (GRAV_RAW > 64'd65535) ? 16'hFFFF : 16'(GRAV_RAW);
    localparam logic [15:0] PADDING_RESET = (PAD_RAW > 64'd65535) ? 16'hFFFF : 16'(PAD_RAW);

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_GRAVITY = 2'd1;
    localparam logic [1:0] CFG_PADDING = 2'd2;

    typedef enum logic [1:0] {
        KIND_PARTICLE = 2'd0,
        KIND_BOX_MIN  = 2'd1,
        KIND_BOX_MAX  = 2'd2
    } t_kind;

    localparam logic [19:0] AGE_MAX = 20'hFFFFF;

    // divide by 1000: radix-16 restoring steps on a biased unsigned dividend
    localparam int DIV_W     = 44;
    localparam int DIV_RADIX = 4;
    localparam int DIV_STEPS = DIV_W / DIV_RADIX;
    localparam int CNT_W     = 4;
    localparam logic [10:0] DIVISOR = 11'd1000;
    // 1000 * 2^32 keeps the dividend positive, +500 rounds half up
    localparam logic [DIV_W-1:0] DIV_BIAS = 44'd4294967296500;
    localparam logic signed [34:0] QUOT_OFFSET = 35'sd4294967296;

    localparam logic signed [34:0] S32_MAX_W = 35'sd2147483647;
    localparam logic signed [34:0] S32_MIN_W = -35'sd2147483648;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             enable;
        logic             move;
        logic             last;
        logic             alive_out;
        logic [19:0]      age_out;
        logic [9:0]       tick;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } t_job;

    typedef struct packed {
        logic [1:0]       kind;
        logic             alive;
        logic [19:0]      age;
        logic [2:0][31:0] pos;
        logic [31:0]      vel_y;
        logic             sys_alive;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [9:0]       rem;
        logic [DIV_W-1:0] quo;
    } t_div_state;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > S32_MAX_W) begin
            return 32'h7FFF_FFFF;
        end else if (v < S32_MIN_W) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_div_state div_step(input logic [9:0] rem, input logic [DIV_W-1:0] quo);
        t_div_state s;
        logic [10:0] trial;
        s.rem = rem;
        s.quo = quo;
        for (int k = 0; k < DIV_RADIX; k++) begin
            trial = {s.rem, s.quo[DIV_W-1]};
            s.quo = {s.quo[DIV_W-2:0], 1'b0};
            if (trial >= DIVISOR) begin
                trial = trial - DIVISOR;
                s.quo[0] = 1'b1;
            end
            s.rem = trial[9:0];
        end
        return s;
    endfunction

endpackage

>>> src/peu_front.sv
module peu_front (
    input  logic              i_valid,
    input  logic              i_alive_in,
    input  logic [9:0]        i_tick_ms,
    input  logic [19:0]       i_age_in,
    input  logic [19:0]       i_age_limit,
    input  logic              i_has_mass,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic              i_tick_last,
    input  logic              i_enable,
    input  logic [15:0]       i_gravity_rate,
    input  logic              i_queue_full,
    output logic              o_stall,
    output logic              o_push,
    output peu_pkg::t_job     o_job
);

    logic [20:0]        age_sum;
    logic [19:0]        age_sat;
    logic               dead;
    logic               active;
    logic [25:0]        grav_dv;
    logic signed [34:0] vy_wide;
    logic [31:0]        vy_new;

    always_comb begin
        age_sum = {1'b0, i_age_in} + 21'(i_tick_ms);
        age_sat = age_sum[20] ? peu_pkg::AGE_MAX : age_sum[19:0];
        dead    = age_sat >= i_age_limit;
        active  = i_enable && i_alive_in;
        grav_dv = 26'(i_gravity_rate) * 26'(i_tick_ms);
        vy_wide = 35'(i_vel_y) - $signed({9'b0, grav_dv});
        vy_new  = peu_pkg::sat32(vy_wide);
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_job.enable    = i_enable;
        o_job.move      = active && !dead;
        o_job.last      = i_tick_last;
        o_job.alive_out = i_enable ? (active && !dead) : i_alive_in;
        o_job.age_out   = active ? age_sat : i_age_in;
        o_job.tick      = i_tick_ms;
        o_job.pos       = {i_pos_z, i_pos_y, i_pos_x};
        o_job.vel       = {i_vel_z, (active && !dead && i_has_mass) ? vy_new : i_vel_y, i_vel_x};
    end

endmodule

>>> src/peu_queue.sv
module peu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  peu_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output peu_pkg::t_job o_job
);

    peu_pkg::t_job               r_mem [peu_pkg::QUEUE_DEPTH];
    logic [peu_pkg::QPTR_W-1:0]  r_wptr;
    logic [peu_pkg::QPTR_W-1:0]  r_rptr;
    logic [peu_pkg::QCNT_W-1:0]  r_count;
    logic                        do_pop;

    assign o_full  = r_count == peu_pkg::QCNT_W'(peu_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == peu_pkg::QPTR_W'(peu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == peu_pkg::QPTR_W'(peu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> src/peu_back.sv
module peu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  peu_pkg::t_job    i_job,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic [15:0]      i_padding,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output peu_pkg::t_result o_result
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_LOAD = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_ADD  = 9'b000010000,
        S_BOX  = 9'b000100000,
        S_EMIT = 9'b001000000,
        S_BMIN = 9'b010000000,
        S_BMAX = 9'b100000000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    peu_pkg::t_job                 r_job;
    logic [31:0]                   r_pos     [3];
    logic signed [42:0]            r_prod    [3];
    logic [peu_pkg::DIV_W-1:0]     r_div     [3];
    logic [9:0]                    r_rem     [3];
    logic [peu_pkg::CNT_W-1:0]     r_cnt;
    logic [31:0]                   r_box_min [3];
    logic [31:0]                   r_box_max [3];
    logic                          r_box_valid;
    logic                          r_ovalid;
    logic                          n_ovalid;
    peu_pkg::t_result              r_result;
    peu_pkg::t_result              n_result;

    logic                          out_free;
    logic                          load_out;
    logic                          box_end;
    logic signed [42:0]            prod_n    [3];
    peu_pkg::t_div_state           step_n    [3];
    logic [31:0]                   pos_n     [3];
    logic [31:0]                   pad_min   [3];
    logic [31:0]                   pad_max   [3];

    assign out_free = !r_ovalid || !i_out_stall;
    assign box_end  = r_job.enable && r_job.last && r_box_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_n[i]  = $signed(r_job.vel[i]) * $signed({1'b0, r_job.tick});
            step_n[i]  = peu_pkg::div_step(r_rem[i], r_div[i]);
            pos_n[i]   = peu_pkg::sat32(35'($signed(r_job.pos[i]))
                                        + $signed({2'b0, r_div[i][32:0]})
                                        - peu_pkg::QUOT_OFFSET);
            pad_min[i] = peu_pkg::sat32(35'($signed(r_box_min[i])) - $signed({19'b0, i_padding}));
            pad_max[i] = peu_pkg::sat32(35'($signed(r_box_max[i])) + $signed({19'b0, i_padding}));
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_job.move ? S_MUL : S_EMIT;
                end
            end
            S_MUL:  n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == peu_pkg::CNT_W'(peu_pkg::DIV_STEPS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD:  n_state = S_BOX;
            S_BOX:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    load_out           = 1'b1;
                    n_result.kind      = peu_pkg::KIND_PARTICLE;
                    n_result.alive     = r_job.alive_out;
                    n_result.age       = r_job.age_out;
                    n_result.pos       = {r_pos[2], r_pos[1], r_pos[0]};
                    n_result.vel_y     = r_job.vel[1];
                    n_result.sys_alive = 1'b0;
                    n_result.last      = !box_end;
                    n_state            = box_end ? S_BMIN : S_IDLE;
                end
            end
            S_BMIN: begin
                if (out_free) begin
                    load_out           = 1'b1;
                    n_result.kind      = peu_pkg::KIND_BOX_MIN;
                    n_result.alive     = 1'b0;
                    n_result.age       = '0;
                    n_result.pos       = {pad_min[2], pad_min[1], pad_min[0]};
                    n_result.vel_y     = '0;
                    n_result.sys_alive = 1'b0;
                    n_result.last      = 1'b0;
                    n_state            = S_BMAX;
                end
            end
            S_BMAX: begin
                if (out_free) begin
                    load_out           = 1'b1;
                    n_result.kind      = peu_pkg::KIND_BOX_MAX;
                    n_result.alive     = 1'b0;
                    n_result.age       = '0;
                    n_result.pos       = {pad_max[2], pad_max[1], pad_max[0]};
                    n_result.vel_y     = '0;
                    n_result.sys_alive = 1'b1;
                    n_result.last      = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_box_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (r_state == S_LOAD) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_BOX) begin
                r_box_valid <= 1'b1;
            end else if (r_state == S_EMIT && out_free && r_job.last && !box_end) begin
                r_box_valid <= 1'b0;
            end else if (r_state == S_BMAX && out_free) begin
                r_box_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_result <= n_result;
        end
        if (r_state == S_IDLE && !i_empty) begin
            r_job <= i_job;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= i_job.pos[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r_state == S_MUL) begin
                r_prod[i] <= prod_n[i];
            end
            if (r_state == S_LOAD) begin
                r_div[i] <= peu_pkg::DIV_W'(r_prod[i]) + peu_pkg::DIV_BIAS;
                r_rem[i] <= '0;
            end
            if (r_state == S_DIV) begin
                r_div[i] <= step_n[i].quo;
                r_rem[i] <= step_n[i].rem;
            end
            if (r_state == S_ADD) begin
                r_pos[i] <= pos_n[i];
            end
            if (r_state == S_BOX) begin
                if (!r_box_valid || $signed(r_pos[i]) < $signed(r_box_min[i])) begin
                    r_box_min[i] <= r_pos[i];
                end
                if (!r_box_valid || $signed(r_pos[i]) > $signed(r_box_max[i])) begin
                    r_box_max[i] <= r_pos[i];
                end
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_result    = r_result;

endmodule

>>> src/particle_euler_update.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// input     | i_valid / o_stall    | particle record, one item per particle
// output    | o_valid / i_stall    | particle result, then box min and max at tick end
// config    | i_cfg_wr_en          | i_cfg_index, i_cfg_data (16 bits)
//
// Pass-through, inactive and dying particles go straight from idle to emit.
// Moving particles pass multiply, load, the 11-step radix-16 divide by 1000
// that runs on all three axes in parallel, add and box before emit.
// A tick end with a box adds the min and max results after the particle result.
// Reset is synchronous, active low; config returns to its defaults, box is emptied.
// A two-item queue sits between front and back, and the output register
// lets the back finish the next item while a result waits.
module particle_euler_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_alive_in,
    input  logic [9:0]         i_tick_ms,
    input  logic [19:0]        i_age_in,
    input  logic [19:0]        i_age_limit,
    input  logic               i_has_mass,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic               i_tick_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_result_kind,
    output logic               o_alive_out,
    output logic [19:0]        o_age_out,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_vel_y_out,
    output logic               o_system_alive,
    output logic               o_result_last
);

    logic             r_sys_enable;
    logic [15:0]      r_gravity_rate;
    logic [15:0]      r_box_padding;

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    peu_pkg::t_job    front_job;
    peu_pkg::t_job    q_job;
    peu_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_enable   <= 1'b1;
            r_gravity_rate <= peu_pkg::GRAVITY_RESET;
            r_box_padding  <= peu_pkg::PADDING_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == peu_pkg::CFG_ENABLE) begin
                r_sys_enable <= i_cfg_data[0];
            end else if (i_cfg_index == peu_pkg::CFG_GRAVITY) begin
                r_gravity_rate <= i_cfg_data;
            end else if (i_cfg_index == peu_pkg::CFG_PADDING) begin
                r_box_padding <= i_cfg_data;
            end
        end
    end

    peu_front u_front (
        .i_valid        (i_valid),
        .i_alive_in     (i_alive_in),
        .i_tick_ms      (i_tick_ms),
        .i_age_in       (i_age_in),
        .i_age_limit    (i_age_limit),
        .i_has_mass     (i_has_mass),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_vel_z        (i_vel_z),
        .i_tick_last    (i_tick_last),
        .i_enable       (r_sys_enable),
        .i_gravity_rate (r_gravity_rate),
        .i_queue_full   (q_full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_job          (front_job)
    );

    peu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    peu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_padding   (r_box_padding),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_result    (result)
    );

    assign o_result_kind  = result.kind;
    assign o_alive_out    = result.alive;
    assign o_age_out      = result.age;
    assign o_out_x        = result.pos[0];
    assign o_out_y        = result.pos[1];
    assign o_out_z        = result.pos[2];
    assign o_vel_y_out    = result.vel_y;
    assign o_system_alive = result.sys_alive;
    assign o_result_last  = result.last;

endmodule

>>> src/peu_checker.sv
module peu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_result_kind,
    input logic        o_alive_out,
    input logic [19:0] o_age_out,
    input logic [31:0] o_out_x,
    input logic [31:0] o_out_y,
    input logic [31:0] o_out_z,
    input logic [31:0] o_vel_y_out,
    input logic        o_system_alive,
    input logic        o_result_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) && $stable(o_out_x)
            && $stable(o_out_y) && $stable(o_out_z) && $stable(o_result_last))
        else $error("stalled result changed");

    a_min_then_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_result_kind == peu_pkg::KIND_BOX_MIN
            |=> o_valid && o_result_kind == peu_pkg::KIND_BOX_MAX)
        else $error("box min not followed by box max");

    a_box_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == peu_pkg::KIND_BOX_MIN
            || o_result_kind == peu_pkg::KIND_BOX_MAX)
            |-> !o_alive_out && o_age_out == '0 && o_vel_y_out == '0
            && (o_result_last == (o_result_kind == peu_pkg::KIND_BOX_MAX)))
        else $error("box result fields wrong");

    a_sys_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_system_alive |-> o_result_last && o_result_kind == peu_pkg::KIND_BOX_MAX)
        else $error("system_alive outside box max");

endmodule

bind particle_euler_update peu_checker u_peu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_kind  (o_result_kind),
    .o_alive_out    (o_alive_out),
    .o_age_out      (o_age_out),
    .o_out_x        (o_out_x),
    .o_out_y        (o_out_y),
    .o_out_z        (o_out_z),
    .o_vel_y_out    (o_vel_y_out),
    .o_system_alive (o_system_alive),
    .o_result_last  (o_result_last)
);

>>> tb/sv/tb_particle_euler_update.sv
module tb_particle_euler_update;
    timeunit 1ns;
    timeprecision 1ps;

    import peu_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        bit             alive;
        bit [9:0]       tick;
        bit [19:0]      age;
        bit [19:0]      limit;
        bit             mass;
        bit [2:0][31:0] pos;
        bit [2:0][31:0] vel;
        bit             tick_last;
    } t_particle;

    typedef struct packed {
        t_kind            kind;
        logic             alive;
        logic [19:0]      age;
        logic [2:0][31:0] pos;
        logic [31:0]      vel_y;
        logic             sys_alive;
        logic             last;
    } t_outcome;

    class particle_ledger;
        bit        enable;
        bit [15:0] gravity;
        bit [15:0] padding;
        longint    box_lo [3];
        longint    box_hi [3];
        bit        box_open;
        bit        any_living;
        t_outcome  due_results [$];
        int        errors;

        function new();
            enable  = 1'b1;
            gravity = 16'd321;
            padding = 16'd3277;
            errors  = 0;
            clear_box();
        endfunction

        function void clear_box();
            for (int i = 0; i < 3; i++) begin
                box_lo[i] = 0;
                box_hi[i] = 0;
            end
            box_open   = 1'b0;
            any_living = 1'b0;
        endfunction

        function void write_reg(bit [1:0] index, bit [15:0] data);
            case (index)
                CFG_ENABLE: begin
                    enable = data[0];
                end
                CFG_GRAVITY: begin
                    gravity = data;
                end
                CFG_PADDING: begin
                    padding = data;
                end
                default: begin
                end
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        static function longint clip32(longint v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // round to nearest, halves go up
        static function longint div_round(longint prod);
            longint n;
            n = prod + 500;
            if (n >= 0) begin
                return n / 1000;
            end
            return -((-n + 999) / 1000);
        endfunction

        function void push(t_kind kind, bit alive, bit [19:0] age, longint x, longint y,
                           longint z, longint vy, bit sys, bit last);
            t_outcome o;
            o.kind      = kind;
            o.alive     = alive;
            o.age       = age;
            o.pos[0]    = x[31:0];
            o.pos[1]    = y[31:0];
            o.pos[2]    = z[31:0];
            o.vel_y     = vy[31:0];
            o.sys_alive = sys;
            o.last      = last;
            due_results.push_back(o);
        endfunction

        function void accept_record(t_particle r);
            longint    p [3];
            longint    v [3];
            longint    pad;
            bit [20:0] age_sum;
            bit [19:0] age;
            bit        live;
            for (int i = 0; i < 3; i++) begin
                p[i] = longint'($signed(r.pos[i]));
                v[i] = longint'($signed(r.vel[i]));
            end
            age  = r.age;
            live = r.alive;
            if (!enable) begin
                push(KIND_PARTICLE, r.alive, r.age, p[0], p[1], p[2], v[1], 1'b0, 1'b1);
                if (r.tick_last) begin
                    clear_box();
                end
                return;
            end
            if (r.alive) begin
                age_sum = r.age + r.tick;
                age = (age_sum > AGE_MAX) ? AGE_MAX : age_sum[19:0];
                if (age >= r.limit) begin
                    live = 1'b0;
                end else begin
                    if (r.mass) begin
                        v[1] = clip32(v[1] - longint'(gravity) * longint'(r.tick));
                    end
                    for (int i = 0; i < 3; i++) begin
                        p[i] = clip32(p[i] + div_round(v[i] * longint'(r.tick)));
                        if (!box_open || p[i] < box_lo[i]) begin
                            box_lo[i] = p[i];
                        end
                        if (!box_open || p[i] > box_hi[i]) begin
                            box_hi[i] = p[i];
                        end
                    end
                    box_open   = 1'b1;
                    any_living = 1'b1;
                end
            end
            if (!r.tick_last || !any_living) begin
                push(KIND_PARTICLE, live, age, p[0], p[1], p[2], v[1], 1'b0, 1'b1);
                if (r.tick_last) begin
                    clear_box();
                end
                return;
            end
            pad = longint'(padding);
            push(KIND_PARTICLE, live, age, p[0], p[1], p[2], v[1], 1'b0, 1'b0);
            push(KIND_BOX_MIN, 1'b0, 20'd0, clip32(box_lo[0] - pad), clip32(box_lo[1] - pad),
                 clip32(box_lo[2] - pad), 0, 1'b0, 1'b0);
            push(KIND_BOX_MAX, 1'b0, 20'd0, clip32(box_hi[0] + pad), clip32(box_hi[1] + pad),
                 clip32(box_hi[2] + pad), 0, 1'b1, 1'b1);
            clear_box();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 200) begin
                $display("mismatch %s: got %h, want %h", what, got, want);
            end
            errors++;
        endtask

        task match_result(t_outcome got);
            t_outcome want;
            if (due_results.size() == 0) begin
                report("result with nothing pending, kind", got.kind, 32'd0);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind) report("result_kind", got.kind, want.kind);
            if (got.alive !== want.alive) report("alive_out", got.alive, want.alive);
            if (got.age !== want.age) report("age_out", got.age, want.age);
            if (got.pos[0] !== want.pos[0]) report("out_x", got.pos[0], want.pos[0]);
            if (got.pos[1] !== want.pos[1]) report("out_y", got.pos[1], want.pos[1]);
            if (got.pos[2] !== want.pos[2]) report("out_z", got.pos[2], want.pos[2]);
            if (got.vel_y !== want.vel_y) report("vel_y_out", got.vel_y, want.vel_y);
            if (got.sys_alive !== want.sys_alive) begin
                report("system_alive", got.sys_alive, want.sys_alive);
            end
            if (got.last !== want.last) report("result_last", got.last, want.last);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [1:0]         i_cfg_index = CFG_ENABLE;
    logic [15:0]        i_cfg_data = 16'd0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_alive_in = 1'b0;
    logic [9:0]         i_tick_ms = 10'd0;
    logic [19:0]        i_age_in = 20'd0;
    logic [19:0]        i_age_limit = 20'd0;
    logic               i_has_mass = 1'b0;
    logic signed [31:0] i_pos_x = 32'sd0;
    logic signed [31:0] i_pos_y = 32'sd0;
    logic signed [31:0] i_pos_z = 32'sd0;
    logic signed [31:0] i_vel_x = 32'sd0;
    logic signed [31:0] i_vel_y = 32'sd0;
    logic signed [31:0] i_vel_z = 32'sd0;
    logic               i_tick_last = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_result_kind;
    logic               o_alive_out;
    logic [19:0]        o_age_out;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [31:0] o_vel_y_out;
    logic               o_system_alive;
    logic               o_result_last;

    particle_ledger board;
    int send_idle = 0;
    int stall_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;

    particle_euler_update u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_alive_in     (i_alive_in),
        .i_tick_ms      (i_tick_ms),
        .i_age_in       (i_age_in),
        .i_age_limit    (i_age_limit),
        .i_has_mass     (i_has_mass),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_vel_z        (i_vel_z),
        .i_tick_last    (i_tick_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_alive_out    (o_alive_out),
        .o_age_out      (o_age_out),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_vel_y_out    (o_vel_y_out),
        .o_system_alive (o_system_alive),
        .o_result_last  (o_result_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receive side: random stall, long hold-off on request, result check
    always @(posedge i_clk) begin : rx_side
        t_outcome seen;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                seen.kind      = t_kind'(o_result_kind);
                seen.alive     = o_alive_out;
                seen.age       = o_age_out;
                seen.pos[0]    = o_out_x;
                seen.pos[1]    = o_out_y;
                seen.pos[2]    = o_out_z;
                seen.vel_y     = o_vel_y_out;
                seen.sys_alive = o_system_alive;
                seen.last      = o_result_last;
                board.match_result(seen);
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb_particle_euler_update: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic t_particle make_record(bit alive, bit [9:0] tick, bit [19:0] age,
                                              bit [19:0] limit, bit mass, bit [31:0] px,
                                              bit [31:0] py, bit [31:0] pz, bit [31:0] vx,
                                              bit [31:0] vy, bit [31:0] vz, bit last);
        t_particle r;
        r.alive     = alive;
        r.tick      = tick;
        r.age       = age;
        r.limit     = limit;
        r.mass      = mass;
        r.pos       = {pz, py, px};
        r.vel       = {vz, vy, vx};
        r.tick_last = last;
        return r;
    endfunction

    function automatic t_particle random_record(bit [9:0] tick);
        t_particle   r;
        int unsigned mode;
        longint      top;
        mode        = $urandom_range(9);
        r.tick      = tick;
        r.tick_last = 1'b0;
        r.mass      = $urandom_range(1);
        r.alive     = 1'b1;
        r.age       = $urandom_range(400000);
        r.limit     = $urandom;
        for (int i = 0; i < 3; i++) begin
            r.pos[i] = ($urandom_range(3) == 0) ? $urandom
                                                 : $urandom_range(32'h00C8_0000) - 32'h0064_0000;
            r.vel[i] = ($urandom_range(3) == 0) ? $urandom
                                                 : $urandom_range(32'h03E8_0000) - 32'h01F4_0000;
        end
        case (mode)
            0: begin
                r.alive = 1'b0;
            end
            1: begin
                top = longint'(r.age) + longint'(tick);
                r.limit = $urandom_range(top > 20'hFFFFF ? 20'hFFFFF : top);
            end
            2: begin
                r.alive = $urandom_range(1);
                r.tick  = $urandom;
                r.age   = $urandom;
                for (int i = 0; i < 3; i++) begin
                    r.pos[i] = $urandom;
                    r.vel[i] = $urandom;
                end
            end
            default: begin
                top = longint'(r.age) + longint'(tick) + 1 + $urandom_range(300000);
                r.limit = (top > 20'hFFFFF) ? 20'hFFFFF : top[19:0];
            end
        endcase
        return r;
    endfunction

    task automatic offer(t_particle r);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_alive_in  <= r.alive;
        i_tick_ms   <= r.tick;
        i_age_in    <= r.age;
        i_age_limit <= r.limit;
        i_has_mass  <= r.mass;
        i_pos_x     <= r.pos[0];
        i_pos_y     <= r.pos[1];
        i_pos_z     <= r.pos[2];
        i_vel_x     <= r.vel[0];
        i_vel_y     <= r.vel[1];
        i_vel_z     <= r.vel[2];
        i_tick_last <= r.tick_last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        board.accept_record(r);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(bit en, bit [15:0] grav, bit [15:0] pad);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= {15'd0, en};
        @(posedge i_clk);
        board.write_reg(CFG_ENABLE, {15'd0, en});
        i_cfg_index <= CFG_GRAVITY;
        i_cfg_data  <= grav;
        @(posedge i_clk);
        board.write_reg(CFG_GRAVITY, grav);
        i_cfg_index <= CFG_PADDING;
        i_cfg_data  <= pad;
        @(posedge i_clk);
        board.write_reg(CFG_PADDING, pad);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_items();
        // reset config
        offer(make_record(0, 37, 500, 1000, 1, 32'h0001_0000, 32'hFFFF_0000, 0,
                          32'h0002_0000, 32'h0003_0000, 32'hFFFE_0000, 0));
        offer(make_record(1, 50, 100, 150, 1, 32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0, 0));
        offer(make_record(1, 1023, 20'hFFFFF, 20'hFFFFF, 0, 1, 2, 3, 4, 5, 6, 0));
        offer(make_record(1, 0, 0, 0, 1, 7, 8, 9, 10, 11, 12, 0));
        offer(make_record(1, 0, 5, 6, 1, 32'h0000_8000, 32'hFFFF_8000, 3, 32'h0001_0000,
                          32'hFFFF_0000, 5, 0));
        offer(make_record(1, 16, 0, 1000, 1, 32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000,
                          32'h0001_8000, 32'h0004_0000, 32'hFFFF_8000, 0));
        offer(make_record(1, 16, 0, 1000, 0, 32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000,
                          32'h0001_8000, 32'h0004_0000, 32'hFFFF_8000, 0));
        // rounding of halves and near-halves
        offer(make_record(1, 1, 0, 10, 0, 0, 0, 0, 500, -500, -1500, 0));
        offer(make_record(1, 1, 0, 10, 0, 0, 0, 0, -501, 1499, -1499, 0));
        // saturation of position and speed
        offer(make_record(1, 1023, 0, 20'hFFFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        offer(make_record(1, 1023, 0, 20'hFFFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        // tick ends with nothing living, then one with a single living particle
        offer(make_record(0, 12, 3, 4, 1, 1, 2, 3, 4, 5, 6, 1));
        offer(make_record(1, 10, 0, 5, 1, 1, 2, 3, 4, 5, 6, 1));
        offer(make_record(1, 20, 100, 5000, 1, 32'h0003_0000, 32'h0001_0000, 32'hFFFD_0000,
                          32'h0010_0000, 32'h0002_0000, 32'hFFF0_0000, 1));
        settle();
        set_regs(1, 16'hFFFF, 16'hFFFF);
        offer(make_record(1, 1023, 0, 20'hFFFFF, 1, 32'h8000_1000, 0, 0, 0, 32'h8010_0000,
                          0, 0));
        offer(make_record(1, 5, 0, 100, 0, 32'h7FFF_8000, 0, 0, 0, 0, 0, 1));
        settle();
        set_regs(1, 16'd321, 16'd3277);
        offer(make_record(1, 8, 0, 100, 1, 32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0));
        settle();
        // disabled system passes items through and drops the open box at tick end
        set_regs(0, 16'h5555, 16'hAAAA);
        offer(make_record(1, 8, 0, 100, 1, 32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0));
        offer(make_record(1, 8, 0, 100, 1, 1, 2, 3, 4, 5, 6, 1));
        settle();
        set_regs(1, 16'd321, 16'd3277);
        offer(make_record(0, 8, 0, 100, 1, 1, 2, 3, 4, 5, 6, 1));
    endtask

    task automatic run_ticks(int count);
        int        sent;
        int        len;
        bit [9:0]  tick;
        t_particle r;
        sent = 0;
        while (sent < count) begin
            len  = $urandom_range(1, 6);
            tick = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
                r = random_record(tick);
                r.tick_last = (k == len - 1);
                if ($urandom_range(19) == 0) begin
                    r.tick_last = $urandom_range(1);
                end
                offer(r);
            end
            sent += len;
        end
    endtask

    task automatic run_phase(int send_pct, int stall_p, bit en, bit [15:0] grav,
                             bit [15:0] pad, int count, bit hold);
        settle();
        send_idle = send_pct;
        stall_pct <= stall_p;
        set_regs(en, grav, pad);
        if (hold) begin
            hold_ask <= hold_ask + 1;
        end
        run_ticks(count);
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_items();
        run_phase(0, 0, 1, $urandom_range(65535), $urandom_range(65535), 40, 0);
        run_phase(68, 0, 1, 16'hFFFF, 16'h0000, 35, 0);
        run_phase(0, 68, 1, 16'h0000, 16'hFFFF, 35, 0);
        run_phase(11, 11, 1, $urandom_range(65535), $urandom_range(65535), 35, 0);
        run_phase(0, 0, 0, $urandom_range(65535), $urandom_range(65535), 15, 1);
        run_phase(0, 0, 1, $urandom_range(1023), $urandom_range(65535), 40, 1);
        settle();
        if (board.errors == 0) begin
            $display("tb_particle_euler_update: done, clean");
        end else begin
            $display("tb_particle_euler_update: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
src/peu_pkg.sv
src/peu_front.sv
src/peu_queue.sv
src/peu_back.sv
src/particle_euler_update.sv
src/peu_checker.sv
tb/sv/tb_particle_euler_update.sv
